// ----- design/tcce_pkg.sv -----
// Shared types and constants for the text console character engine.
// No dependencies; every other file of the block but tcce_chan_if refers to this package.
`timescale 1ns / 1ps

package tcce_pkg;

  // Fixed field widths of the channel words
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int LIN_W  = ROW_W + COL_W;

  // Control characters and fill values
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR  = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_COLOR = 8'h0F;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    op_e               opcode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  target_row;
    logic [COL_W-1:0]  target_col;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_word;
    logic              scrolled;
  } res_t;

endpackage

// ----- design/tcce_chan_if.sv -----
// Valid/ready channel interface carrying one word of a payload type.
// Used for the command and result channels; payload types come from tcce_pkg.
`timescale 1ns / 1ps

interface tcce_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/text_console_char_engine_unit.sv -----
// Top level of the text console character engine: sequencer, screen RAM, result register.
// Depends on tcce_pkg, tcce_chan_if, tcce_ctrl and tcce_screen_ram.
//
//   port          dir   handshake        word
//   in_i          in    valid/ready      opcode, char_code, target_row, target_col
//   out_o         out   valid/ready      cursor_row, cursor_col, cursor_pos, cell_word, scrolled
//   cfg_we_i      in    write enable     cfg_wdata_i = text_color
//
// Put character and set cursor pass through EXEC and DONE before the next accept; read cell
// passes through EXEC, READ and DONE. A put that passes the bottom line also blanks the new
// line through the single RAM port; scrolling itself only moves the row offset. Clear blanks
// every cell. After reset the RAM is filled with blanks before the first word is accepted.
// The result register takes a finished word while the output is stalled; a second
// result waits in the sequencer until the register empties.
`timescale 1ns / 1ps

module text_console_char_engine_unit #(
  parameter int ROWS     = 25,
  parameter int COLS     = 80,
  parameter int TAB_STOP = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0] cfg_wdata_i,
  tcce_chan_if.sink                   in_i,
  tcce_chan_if.source                 out_o
);

  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);

  logic                        res_valid, res_ready;
  tcce_pkg::res_t              res_data;
  logic                        ram_we, ram_re;
  logic [ADDR_W-1:0]           ram_addr;
  logic [tcce_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
  logic                        out_valid_q;
  tcce_pkg::res_t              out_data_q;

  tcce_ctrl #(
    .ROWS     (ROWS),
    .COLS     (COLS),
    .TAB_STOP (TAB_STOP),
    .CELLS    (CELLS),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_i.data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  tcce_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Result register: load when empty or being drained
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ----- design/tcce_screen_ram.sv -----
// Screen cell store: single-port synchronous RAM with a registered read.
// Depends on tcce_pkg for the cell width.
`timescale 1ns / 1ps

module tcce_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [ADDR_W-1:0]          addr_i,
  input  logic [tcce_pkg::CELL_W-1:0] wdata_i,
  output logic [tcce_pkg::CELL_W-1:0] rdata_o
);

  logic [tcce_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tcce_pkg::CELL_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tcce_ctrl.sv -----
// Command sequencer: cursor, scroll offset, fill sweeps and screen RAM accesses.
// Depends on tcce_pkg; drives the port of tcce_screen_ram.
`timescale 1ns / 1ps

module tcce_ctrl #(
  parameter int ROWS     = 25,
  parameter int COLS     = 80,
  parameter int TAB_STOP = 4,
  parameter int CELLS    = 2000,
  parameter int ADDR_W   = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tcce_pkg::in_t                 in_data_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output tcce_pkg::res_t                res_data_o,
  output logic                          ram_we_o,
  output logic                          ram_re_o,
  output logic [ADDR_W-1:0]             ram_addr_o,
  output logic [tcce_pkg::CELL_W-1:0]   ram_wdata_o,
  input  logic [tcce_pkg::CELL_W-1:0]   ram_rdata_i
);

  localparam int ROW_W  = tcce_pkg::ROW_W;
  localparam int COL_W  = tcce_pkg::COL_W;
  localparam int RX_W   = ROW_W + 1;
  localparam int CIDX_W = $clog2(COLS);
  localparam int LIN_W  = tcce_pkg::LIN_W;
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
  localparam logic [RX_W-1:0]   ROWS_X    = RX_W'(ROWS);

  tcce_pkg::ctrl_state_e state_q, state_d;
  tcce_pkg::in_t         op_q;
  logic [ROW_W-1:0]            row_q, row_d, top_q, top_d;
  logic [COL_W-1:0]            col_q, col_d;
  logic [tcce_pkg::ATTR_W-1:0] color_q;
  logic [tcce_pkg::CELL_W-1:0] fill_q, fill_d, cell_q, cell_d;
  logic [ADDR_W-1:0]           sweep_q, sweep_d, last_q, last_d;
  logic                        scr_q, scr_d;

  logic [ROW_W-1:0]            addr_row, phys_row;
  logic [COL_W-1:0]            addr_col;
  logic [RX_W-1:0]             phys_sum, row_x;
  logic [ADDR_W-1:0]           cell_addr, scroll_base;
  logic [tcce_pkg::CELL_W-1:0] blank;
  logic                        in_rng, accept;
  logic [LIN_W-1:0]            lin_pos;

  // Tab stop table, one entry per column
  logic [COL_W-1:0] tab_col  [COLS];
  logic             tab_wrap [COLS];

  for (genvar g = 0; g < COLS; g++) begin : g_tab
    localparam int NextStop = ((g / TAB_STOP) + 1) * TAB_STOP;
    assign tab_col[g]  = (NextStop >= COLS) ? '0 : COL_W'(NextStop);
    assign tab_wrap[g] = (NextStop >= COLS);
  end

  // Map a logical row through the scroll offset to a RAM address
  assign phys_sum  = {1'b0, addr_row} + {1'b0, top_q};
  assign phys_row  = (phys_sum >= ROWS_X) ? ROW_W'(phys_sum - ROWS_X)
                                          : phys_sum[ROW_W-1:0];
  assign cell_addr   = ADDR_W'(phys_row) * ADDR_W'(COLS) + ADDR_W'(addr_col);
  assign scroll_base = ADDR_W'(top_q) * ADDR_W'(COLS);

  assign blank  = {color_q, tcce_pkg::BLANK_CHAR};
  assign in_rng = ({1'b0, op_q.target_row} < ROWS_X) &&
                  ({1'b0, op_q.target_col} < (COL_W + 1)'(COLS));
  assign accept = in_ready_o && in_valid_i;

  // Result word
  assign lin_pos = LIN_W'(row_q) * LIN_W'(COLS) + LIN_W'(col_q);
  assign res_data_o.cursor_row = row_q;
  assign res_data_o.cursor_col = col_q;
  assign res_data_o.cursor_pos = lin_pos[tcce_pkg::POS_W-1:0];
  assign res_data_o.cell_word  = cell_q;
  assign res_data_o.scrolled   = scr_q;

  // Next state and RAM control
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    top_d       = top_q;
    fill_d      = fill_q;
    sweep_d     = sweep_q;
    last_d      = last_q;
    cell_d      = cell_q;
    scr_d       = scr_q;
    addr_row    = row_q;
    addr_col    = col_q;
    row_x       = {1'b0, row_q};
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = cell_addr;
    ram_wdata_o = fill_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      tcce_pkg::ST_INIT, tcce_pkg::ST_CLEAR, tcce_pkg::ST_SCROLL: begin
        // Sweep the fill value over a range of cells
        ram_we_o   = 1'b1;
        ram_addr_o = sweep_q;
        if (sweep_q == last_q) begin
          state_d = (state_q == tcce_pkg::ST_INIT) ? tcce_pkg::ST_IDLE
                                                   : tcce_pkg::ST_DONE;
        end else begin
          sweep_d = sweep_q + ADDR_W'(1);
        end
      end

      tcce_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = tcce_pkg::ST_EXEC;
          cell_d  = '0;
          scr_d   = 1'b0;
        end
      end

      tcce_pkg::ST_EXEC: begin
        case (op_q.opcode)
          tcce_pkg::OP_PUT: begin
            case (op_q.char_code)
              tcce_pkg::CH_LF: begin
                row_x = {1'b0, row_q} + RX_W'(1);
                col_d = '0;
              end
              tcce_pkg::CH_CR: begin
                col_d = '0;
              end
              tcce_pkg::CH_TAB: begin
                col_d = tab_col[col_q[CIDX_W-1:0]];
                row_x = {1'b0, row_q} + RX_W'(tab_wrap[col_q[CIDX_W-1:0]]);
              end
              tcce_pkg::CH_BS: begin
                // Erase only when not at the left edge
                if (col_q != '0) begin
                  col_d       = col_q - COL_W'(1);
                  addr_col    = col_q - COL_W'(1);
                  ram_we_o    = 1'b1;
                  ram_wdata_o = blank;
                end
              end
              default: begin
                ram_we_o    = 1'b1;
                ram_wdata_o = {color_q, op_q.char_code};
                if (col_q == LAST_COL) begin
                  col_d = '0;
                  row_x = {1'b0, row_q} + RX_W'(1);
                end else begin
                  col_d = col_q + COL_W'(1);
                end
              end
            endcase
            // Past the bottom: advance the scroll offset and blank the new line
            if (row_x == ROWS_X) begin
              row_d   = LAST_ROW;
              scr_d   = 1'b1;
              fill_d  = blank;
              sweep_d = scroll_base;
              last_d  = scroll_base + ROW_SPAN;
              top_d   = (top_q == LAST_ROW) ? '0 : top_q + ROW_W'(1);
              state_d = tcce_pkg::ST_SCROLL;
            end else begin
              row_d   = row_x[ROW_W-1:0];
              state_d = tcce_pkg::ST_DONE;
            end
          end
          tcce_pkg::OP_SET: begin
            if (in_rng) begin
              row_d = op_q.target_row;
              col_d = op_q.target_col;
            end
            state_d = tcce_pkg::ST_DONE;
          end
          tcce_pkg::OP_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            top_d   = '0;
            fill_d  = blank;
            sweep_d = '0;
            last_d  = LAST_CELL;
            state_d = tcce_pkg::ST_CLEAR;
          end
          tcce_pkg::OP_READ: begin
            addr_row = op_q.target_row;
            addr_col = op_q.target_col;
            ram_re_o = in_rng;
            state_d  = tcce_pkg::ST_READ;
          end
          default: begin
            state_d = tcce_pkg::ST_DONE;
          end
        endcase
      end

      tcce_pkg::ST_READ: begin
        if (in_rng) begin
          cell_d = ram_rdata_i;
        end
        state_d = tcce_pkg::ST_DONE;
      end

      tcce_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = tcce_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tcce_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcce_pkg::ST_INIT;
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      color_q <= tcce_pkg::RESET_COLOR;
      fill_q  <= {tcce_pkg::RESET_COLOR, tcce_pkg::BLANK_CHAR};
      sweep_q <= '0;
      last_q  <= LAST_CELL;
      scr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      fill_q  <= fill_d;
      sweep_q <= sweep_d;
      last_q  <= last_d;
      scr_q   <= scr_d;
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    if (accept) begin
      op_q <= in_data_i;
    end
  end

endmodule

// ----- design/tcce_checker.sv -----
// Port-level checks on the result channel of text_console_char_engine_unit.
// Depends on tcce_pkg; attached to the top level by the bind at the end.
`timescale 1ns / 1ps

module tcce_checker #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input tcce_pkg::res_t out_data_i
);

  logic [tcce_pkg::LIN_W-1:0] lin;

  assign lin = tcce_pkg::LIN_W'(out_data_i.cursor_row) * tcce_pkg::LIN_W'(COLS)
             + tcce_pkg::LIN_W'(out_data_i.cursor_col);

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (int'(out_data_i.cursor_row) < ROWS) &&
                    (int'(out_data_i.cursor_col) < COLS))
    else $error("cursor off screen");

  // Linear position agrees with row and column
  a_cursor_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.cursor_pos == lin[tcce_pkg::POS_W-1:0])
    else $error("cursor position mismatch");

  // A scroll leaves the cursor on the bottom line
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.scrolled |-> int'(out_data_i.cursor_row) == ROWS - 1)
    else $error("scroll without cursor on bottom line");

endmodule

bind text_console_char_engine_unit tcce_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_tcce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
